// ----- hw/rtl/register_datagram_codec_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the register datagram codec checkers
// ----------------------------------------------------------------------------
`ifndef REGISTER_DATAGRAM_CODEC_CORE_MACROS_SVH
`define REGISTER_DATAGRAM_CODEC_CORE_MACROS_SVH

// Property checked only outside reset.
`define RDC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define RDC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/rdc_pkg.sv -----
// ----------------------------------------------------------------------------
// rdc_pkg
// Types, codes and the CRC-8 step shared by the register datagram codec.
// ----------------------------------------------------------------------------
`default_nettype none

package rdc_pkg;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_REPLY = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  localparam logic KIND_TX    = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  localparam logic [7:0] SYNC_BYTE  = 8'h05;
  localparam logic [7:0] WRITE_FLAG = 8'h80;
  localparam logic [7:0] READ_MASK  = 8'h7F;
  localparam logic [7:0] CRC_POLY   = 8'h07;

  // Frame shifter bytes before the CRC byte, and reply bytes before its CRC.
  localparam logic [2:0] WRITE_BYTES = 3'd7;
  localparam logic [2:0] READ_BYTES  = 3'd3;
  localparam logic [2:0] REPLY_LAST  = 3'd5;

  typedef struct packed {
    func_t       func;
    logic [7:0]  node_address;
    logic [6:0]  reg_address;
    logic [31:0] write_data;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  tx_byte;
    logic        tx_last;
    logic [31:0] reply_value;
    logic        reply_crc_ok;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic last;
  } ser_status_t;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
    logic        crc_ok;
  } reply_status_t;

  // MSB-first CRC-8, one byte.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rdc_in_if.sv -----
// ----------------------------------------------------------------------------
// rdc_in_if
// Valid/ready channel carrying codec request and reply-byte beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdc_in_if;
  import rdc_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rdc_out_if.sv -----
// ----------------------------------------------------------------------------
// rdc_out_if
// Valid/ready channel carrying transmit bytes and reply-complete beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface rdc_out_if;
  import rdc_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rdc_reply.sv -----
// ----------------------------------------------------------------------------
// rdc_reply
// Reply assembler: byte count, running CRC and the 32-bit value.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_reply (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  update,
  input  wire rdc_pkg::func_t        func,
  input  wire logic [7:0]            rx_byte,
  output rdc_pkg::reply_status_t     status
);
  import rdc_pkg::*;

  logic [2:0]  count;
  logic [7:0]  crc;
  logic [31:0] data;
  logic [31:0] data_next;
  logic [1:0]  lane;

  assign lane = count[1:0] - 2'd1;

  always_comb begin
    data_next = data;
    case (lane)
      2'd0:    data_next[7:0]   = data[7:0]   | rx_byte;
      2'd1:    data_next[15:8]  = data[15:8]  | rx_byte;
      2'd2:    data_next[23:16] = data[23:16] | rx_byte;
      2'd3:    data_next[31:24] = data[31:24] | rx_byte;
      default: data_next = data;
    endcase
  end

  always_comb begin
    status.done   = (count >= REPLY_LAST);
    status.value  = data;
    status.crc_ok = (crc == rx_byte);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      crc   <= '0;
      data  <= '0;
    end else if (update) begin
      if (func == FUNC_READ || (func == FUNC_REPLY && status.done)) begin
        count <= '0;
        crc   <= '0;
        data  <= '0;
      end else if (func == FUNC_REPLY) begin
        crc   <= crc8_step(crc, rx_byte);
        count <= count + 3'd1;
        // byte 0 only feeds the CRC
        if (count != 3'd0) begin
          data <= data_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rdc_frame_ser.sv -----
// ----------------------------------------------------------------------------
// rdc_frame_ser
// Request frame shifter: one byte per beat, CRC folded in as bytes leave.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_frame_ser (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire rdc_pkg::in_item_t item,
  input  wire logic              advance,
  output rdc_pkg::ser_status_t   status,
  output rdc_pkg::out_item_t     beat
);
  import rdc_pkg::*;

  logic        busy;
  logic [2:0]  count;
  logic [55:0] bytes;
  logic [7:0]  crc;

  always_comb begin
    status.busy = busy;
    status.last = busy && (count == 3'd0);
    beat.out_kind     = KIND_TX;
    beat.tx_byte      = (count == 3'd0) ? crc : bytes[7:0];
    beat.tx_last      = (count == 3'd0);
    beat.reply_value  = '0;
    beat.reply_crc_ok = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (advance && busy && count == 3'd0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      crc <= '0;
      if (item.func == FUNC_WRITE) begin
        count <= WRITE_BYTES;
        bytes <= {item.write_data, {1'b0, item.reg_address} | WRITE_FLAG,
                  item.node_address, SYNC_BYTE};
      end else begin
        count <= READ_BYTES;
        bytes <= {32'd0, {1'b0, item.reg_address} & READ_MASK,
                  item.node_address, SYNC_BYTE};
      end
    end else if (advance && busy && count != 3'd0) begin
      crc   <= crc8_step(crc, bytes[7:0]);
      bytes <= {8'd0, bytes[55:8]};
      count <= count - 3'd1;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/register_datagram_codec_core.sv -----
// ----------------------------------------------------------------------------
// register_datagram_codec_core
// Builds register-bus request frames and assembles six-byte replies.
// ----------------------------------------------------------------------------
// Usage:
//   items   - input beats. func 0 sends a write frame (8 bytes), func 1 a
//             read frame (4 bytes, also restarts reply assembly), func 2
//             hands in one received reply byte, func 3 is dropped.
//   results - output beats: transmit bytes (out_kind 0, tx_last on the CRC
//             byte) or a reply-complete beat (out_kind 1) on every sixth
//             reply byte, with the value and the CRC match flag.
//   A first transmit byte passes the holding register, the frame shifter
//   and the output register; a reply-complete beat skips the shifter.
//   Throughput: the frame shifter sends one byte per cycle unless results
//   stalls, so a write holds the frame path for its 8 bytes, a read for
//   its 4; reply bytes that complete nothing pass at one per cycle. One
//   item waits in a holding register while a frame is still going out.
//   Reset clears the reply count, CRC and value and empties every stage.
//   A stall on results holds the output register; a request or completing
//   reply byte then fills the holding register and items.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module register_datagram_codec_core (
  input wire logic    clk,
  input wire logic    rst,
  rdc_in_if.sink      items,
  rdc_out_if.source   results
);
  import rdc_pkg::*;

  logic          item_valid;
  in_item_t      item;
  logic          out_valid;
  out_item_t     out_data;

  ser_status_t   ser_status;
  out_item_t     ser_beat;
  reply_status_t rep_status;

  logic out_take;
  logic ser_free;
  logic item_is_req;
  logic item_completes;
  logic item_adv;
  logic ser_emit;
  logic rep_push;

  assign out_take       = !out_valid || results.ready;
  assign ser_emit       = ser_status.busy && out_take;
  assign ser_free       = !ser_status.busy || (out_take && ser_status.last);
  assign item_is_req    = (item.func == FUNC_WRITE) || (item.func == FUNC_READ);
  assign item_completes = (item.func == FUNC_REPLY) && rep_status.done;

  always_comb begin
    if (!item_valid) begin
      item_adv = 1'b0;
    end else if (item_is_req) begin
      item_adv = ser_free;
    end else if (item_completes) begin
      // hold until the frame in flight has fully gone out
      item_adv = !ser_status.busy && out_take;
    end else begin
      item_adv = 1'b1;
    end
  end

  assign rep_push    = item_adv && item_completes;
  assign items.ready = !item_valid || item_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (items.valid && items.ready) begin
      item_valid <= 1'b1;
    end else if (item_adv) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (items.valid && items.ready) begin
      item <= items.payload;
    end
  end

  rdc_frame_ser u_ser (
    .clk     (clk),
    .rst     (rst),
    .load    (item_adv && item_is_req),
    .item    (item),
    .advance (out_take),
    .status  (ser_status),
    .beat    (ser_beat)
  );

  rdc_reply u_reply (
    .clk     (clk),
    .rst     (rst),
    .update  (item_adv),
    .func    (item.func),
    .rx_byte (item.rx_byte),
    .status  (rep_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ser_emit || rep_push) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ser_emit) begin
      out_data <= ser_beat;
    end else if (rep_push) begin
      out_data.out_kind     <= KIND_REPLY;
      out_data.tx_byte      <= '0;
      out_data.tx_last      <= 1'b0;
      out_data.reply_value  <= rep_status.value;
      out_data.reply_crc_ok <= rep_status.crc_ok;
    end
  end

  assign results.valid   = out_valid;
  assign results.payload = out_data;

endmodule

`default_nettype wire

// ----- hw/rtl/rdc_checker.sv -----
// ----------------------------------------------------------------------------
// rdc_checker
// Port-level checks on the register datagram codec, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "register_datagram_codec_core_macros.svh"

module rdc_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire rdc_pkg::out_item_t out_payload
);
  import rdc_pkg::*;

  logic stalled;
  logic reply_beat;
  logic tx_beat;
  logic reply_clean;
  logic tx_clean;

  assign stalled     = out_valid && !out_ready;
  assign reply_beat  = out_valid && (out_payload.out_kind == KIND_REPLY);
  assign tx_beat     = out_valid && (out_payload.out_kind == KIND_TX);
  assign reply_clean = (out_payload.tx_byte == 8'd0) && !out_payload.tx_last;
  assign tx_clean    = (out_payload.reply_value == 32'd0) && !out_payload.reply_crc_ok;

  // a stalled result beat stays put
  `RDC_ASSERT(a_out_hold, clk, rst, stalled |=> out_valid && $stable(out_payload), "beat moved")

  `RDC_ASSERT(a_reply_fields, clk, rst, reply_beat |-> reply_clean, "tx fields on reply beat")

  `RDC_ASSERT(a_tx_fields, clk, rst, tx_beat |-> tx_clean, "reply fields on tx beat")

  // reset empties both stages
  `RDC_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid && in_ready, "not empty after reset")

endmodule

bind register_datagram_codec_core rdc_checker u_rdc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (items.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .out_payload (results.payload)
);

`default_nettype wire

// ----- tb/sv/rdc_tb_pkg.sv -----
// ----------------------------------------------------------------------------
// rdc_tb_pkg
// Scoreboard for the register datagram codec: predicts request frames and
// reply-complete beats from accepted input beats, checks output beats.
// ----------------------------------------------------------------------------
`default_nettype none

package rdc_tb_pkg;
  import rdc_pkg::*;

  class datagram_scoreboard;
    out_item_t   expected_q[$];
    logic [2:0]  reply_bytes_seen;
    logic [7:0]  reply_crc_acc;
    logic [31:0] reply_value_acc;
    int          errors;

    function new();
      expected_q.delete();
      errors = 0;
      clear_reply();
    endfunction

    function void clear_reply();
      reply_bytes_seen = '0;
      reply_crc_acc    = '0;
      reply_value_acc  = '0;
    endfunction

    // MSB-first CRC-8, one data bit per step.
    static function logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
        fb = c[7] ^ data[i];
        c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return c;
    endfunction

    function void push_frame(input logic [7:0] frame[7], input int n);
      out_item_t  beat;
      logic [7:0] crc;
      crc = '0;
      for (int k = 0; k <= n; k++) begin
        beat              = '0;
        beat.out_kind     = KIND_TX;
        if (k < n) begin
          beat.tx_byte = frame[k];
          crc          = crc_byte(crc, frame[k]);
        end else begin
          beat.tx_byte = crc;
          beat.tx_last = 1'b1;
        end
        expected_q.push_back(beat);
      end
    endfunction

    function void note_item(input in_item_t it);
      logic [7:0] frame[7];
      out_item_t  beat;
      foreach (frame[k]) frame[k] = '0;
      case (it.func)
        FUNC_WRITE: begin
          frame[0] = SYNC_BYTE;
          frame[1] = it.node_address;
          frame[2] = {1'b0, it.reg_address} | WRITE_FLAG;
          for (int k = 0; k < 4; k++) frame[3 + k] = it.write_data[8 * k +: 8];
          push_frame(frame, 7);
        end
        FUNC_READ: begin
          frame[0] = SYNC_BYTE;
          frame[1] = it.node_address;
          frame[2] = {1'b0, it.reg_address} & READ_MASK;
          clear_reply();
          push_frame(frame, 3);
        end
        FUNC_REPLY: begin
          if (reply_bytes_seen >= REPLY_LAST) begin
            beat              = '0;
            beat.out_kind     = KIND_REPLY;
            beat.reply_value  = reply_value_acc;
            beat.reply_crc_ok = (reply_crc_acc == it.rx_byte);
            expected_q.push_back(beat);
            clear_reply();
          end else begin
            reply_crc_acc = crc_byte(reply_crc_acc, it.rx_byte);
            if (reply_bytes_seen != 0)
              reply_value_acc[8 * (reply_bytes_seen - 1) +: 8] = it.rx_byte;
            reply_bytes_seen = reply_bytes_seen + 3'd1;
          end
        end
        default: ;
      endcase
    endfunction

    task report(input string msg);
      errors++;
      if (errors <= 50) $display("MISMATCH: %s", msg);
    endtask

    task check_result(input out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected beat %h", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.out_kind !== want.out_kind)
        report($sformatf("out_kind got %0b want %0b", got.out_kind, want.out_kind));
      if (got.tx_byte !== want.tx_byte)
        report($sformatf("tx_byte got %h want %h", got.tx_byte, want.tx_byte));
      if (got.tx_last !== want.tx_last)
        report($sformatf("tx_last got %0b want %0b", got.tx_last, want.tx_last));
      if (got.reply_value !== want.reply_value)
        report($sformatf("reply_value got %h want %h", got.reply_value, want.reply_value));
      if (got.reply_crc_ok !== want.reply_crc_ok)
        report($sformatf("reply_crc_ok got %0b want %0b", got.reply_crc_ok,
                         want.reply_crc_ok));
    endtask

    task flush_leftovers();
      while (expected_q.size() != 0) begin
        report($sformatf("beat never arrived %h", expected_q.pop_front()));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives write, read and reply-byte beats into the register datagram codec
// with random gaps and output stalls, and checks every output beat against
// the scoreboard's prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rdc_pkg::*;
  import rdc_tb_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int ITEM_TARGET = 310;
  localparam int IDLE_LIMIT  = 3000;
  localparam int LONG_HOLD   = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rdc_in_if  in_ch ();
  rdc_out_if out_ch ();

  register_datagram_codec_core dut (
    .clk     (clk),
    .rst     (rst),
    .items   (in_ch),
    .results (out_ch)
  );

  datagram_scoreboard sb = new();

  int sent_items   = 0;
  int results_seen = 0;
  int idle_cycles  = 0;
  bit quiet        = 1'b1;

  always #HALF_PERIOD clk = ~clk;

  // Mostly short gaps, a few long ones, none in quiet stretches.
  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t random_item(input func_t f);
    in_item_t it;
    it.func         = f;
    it.node_address = 8'($urandom);
    it.reg_address  = 7'($urandom);
    it.write_data   = $urandom;
    it.rx_byte      = 8'($urandom);
    return it;
  endfunction

  task automatic offer(input in_item_t it);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(it);
    if (it.func != FUNC_NONE) sent_items++;
  endtask

  task automatic send_request(input func_t f, input logic [7:0] node,
                              input logic [6:0] addr, input logic [31:0] data);
    in_item_t it;
    it              = random_item(f);
    it.node_address = node;
    it.reg_address  = addr;
    it.write_data   = data;
    offer(it);
  endtask

  task automatic send_reply_bytes(input logic [7:0] frame[6], input int first,
                                  input int count);
    in_item_t it;
    for (int k = first; k < first + count; k++) begin
      it         = random_item(FUNC_REPLY);
      it.rx_byte = frame[k];
      offer(it);
    end
  endtask

  function automatic void build_reply(input logic [31:0] value, input bit crc_good,
                                      output logic [7:0] frame[6]);
    logic [7:0] crc;
    frame[0] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : SYNC_BYTE;
    for (int k = 1; k <= 4; k++) frame[k] = value[8 * (k - 1) +: 8];
    crc = '0;
    for (int k = 0; k < 5; k++) crc = datagram_scoreboard::crc_byte(crc, frame[k]);
    frame[5] = crc_good ? crc : crc ^ 8'($urandom_range(1, 255));
  endfunction

  // Accepted beats on the output side.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.payload);
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stalls plus one long hold to back up the block.
  initial begin
    int  n;
    bit  hold_pending;
    hold_pending = 1'b1;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_pending && results_seen >= 60) begin
        hold_pending = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    in_item_t   it;
    logic [7:0] frame[6];
    int         pick;
    int         n;

    in_ch.valid   <= 1'b0;
    in_ch.payload <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every func code, reply corner cases.
    send_request(FUNC_WRITE, 8'h00, 7'h00, 32'h0000_0000);
    send_request(FUNC_WRITE, 8'hFF, 7'h7F, 32'hFFFF_FFFF);
    send_request(FUNC_READ, 8'h00, 7'h00, 32'hFFFF_FFFF);
    send_request(FUNC_READ, 8'hFF, 7'h7F, 32'h0000_0000);
    offer(random_item(FUNC_NONE));
    send_request(FUNC_READ, 8'h11, 7'h6C, $urandom);
    build_reply(32'hFFFF_0000, 1'b1, frame);
    send_reply_bytes(frame, 0, 6);
    // reply with no read ahead of it and a bad CRC
    build_reply(32'h0000_00FF, 1'b0, frame);
    send_reply_bytes(frame, 0, 6);
    // a write in the middle of a reply leaves it intact
    build_reply(32'hA5C3_5A3C, 1'b1, frame);
    send_reply_bytes(frame, 0, 2);
    send_request(FUNC_WRITE, 8'h5A, 7'h2A, 32'h8000_0001);
    send_reply_bytes(frame, 2, 4);

    quiet = 1'b0;
    while (sent_items < ITEM_TARGET) begin
      if ($urandom_range(0, 15) == 0) quiet = !quiet;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_request(FUNC_WRITE, 8'($urandom), 7'($urandom), $urandom);
      end else if (pick < 55) begin
        send_request(FUNC_READ, 8'($urandom), 7'($urandom), $urandom);
        build_reply($urandom, $urandom_range(0, 3) != 0, frame);
        send_reply_bytes(frame, 0, 6);
      end else if (pick < 70) begin
        // broken reply: cut short, then whatever follows
        send_request(FUNC_READ, 8'($urandom), 7'($urandom), $urandom);
        build_reply($urandom, 1'b1, frame);
        send_reply_bytes(frame, 0, $urandom_range(1, 5));
      end else if (pick < 85) begin
        n = $urandom_range(1, 8);
        repeat (n) offer(random_item(FUNC_REPLY));
      end else if (pick < 95) begin
        offer(random_item(FUNC_NONE));
      end else begin
        send_request(FUNC_READ, 8'($urandom), 7'($urandom), $urandom);
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    sb.flush_leftovers();
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/rdc_pkg.sv
hw/rtl/rdc_in_if.sv
hw/rtl/rdc_out_if.sv
hw/rtl/rdc_reply.sv
hw/rtl/rdc_frame_ser.sv
hw/rtl/register_datagram_codec_core.sv
hw/rtl/rdc_checker.sv
tb/sv/rdc_tb_pkg.sv
tb/sv/tb_top.sv
